// ===== sv/long_term_reference_frame_policy_defines.svh =====
// ----------------------------------------------------------------------------
// Long-term reference frame policy assertion macros
// Shared concurrent assertion forms for the policy RTL.
// ----------------------------------------------------------------------------
`ifndef LONG_TERM_REFERENCE_FRAME_POLICY_DEFINES_SVH
`define LONG_TERM_REFERENCE_FRAME_POLICY_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define LTRFP_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ltrfp assertion failed");

// An implication checked at every clock edge outside reset.
`define LTRFP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ltrfp assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define LTRFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ltrfp assertion failed");

`endif

// ===== sv/ltrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Long-term reference frame policy package
// Types, constants and codes shared by the policy modules.
// ----------------------------------------------------------------------------
package ltrfp_pkg;

   localparam int MAX_INFLIGHT = 60;
   localparam int TABLE_DEPTH  = MAX_INFLIGHT + 1;
   localparam int IDX_W        = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_W      = 64;
   localparam int TAG_W        = 32;
   localparam int DELAY_W      = 16;

   localparam logic [DELAY_W-1:0] RETRY_DELAY_RESET = DELAY_W'(60);

   typedef enum logic [2:0] {
      CMD_NEXT        = 3'd0,
      CMD_ACK         = 3'd1,
      CMD_NACK        = 3'd2,
      CMD_BROKEN      = 3'd3,
      CMD_FORCE_INTRA = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_NORMAL = 2'd0,
      KIND_INTRA  = 2'd1,
      KIND_CREATE = 2'd2,
      KIND_REFER  = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      STATUS_OK        = 1'b0,
      STATUS_NOT_FOUND = 1'b1
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] ref_count;
      logic [TAG_W-1:0]   tag;
      kind_type           kind;
      logic               slot;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_req_type;

   typedef struct packed {
      logic             valid;
      logic [2:0]       command;
      logic [TAG_W-1:0] frame_tag;
   } start_type;

   typedef struct packed {
      logic       idle;
      logic       done;
      status_type status;
      kind_type   coding_kind;
      logic       slot;
   } ctrl_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CMP_RD,
      S_CMP_WR,
      S_APPEND,
      S_FIND_RD,
      S_FIND_CHK,
      S_ACK_FIRST,
      S_ACK_RD,
      S_ACK_CHK,
      S_BRK_RD,
      S_NK_FIRST,
      S_NK_RDK,
      S_NK_GOTK,
      S_NK_RDJ,
      S_NK_CHKJ,
      S_DONE
   } state_type;

endpackage

// ===== sv/long_term_reference_frame_policy.sv =====
// ----------------------------------------------------------------------------
// Long-term reference frame policy
// Chooses each frame's coding type and tracks acks and nacks of frames.
// ----------------------------------------------------------------------------
// A next action appends its frame to the table; a full table first drops its oldest entry
// and compacts the kept entries. Ack and nack first search the table for the tag; ack
// then walks back over older entries along the chain the acked frame refers to, nack
// checks each later entry against the marked entries (it grows with the square of later
// entries), and both then compact the table over the kept entries.
// Throughput: one word at a time; req_stall is high until the result is handed off.
// Reset (synchronous, active high) empties the table and clears all recovery state.
module long_term_reference_frame_policy (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_command,
   input  logic [ltrfp_pkg::TAG_W-1:0]         req_frame_tag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic [1:0]                          rsp_coding_kind,
   output logic                                rsp_long_term_slot,
   input  logic                                csr_wr_en,
   input  logic [ltrfp_pkg::DELAY_W-1:0]       csr_wr_data
);
   import ltrfp_pkg::*;

   // The user must write the retry delay register only while no word is in work; the block itself does not enforce it.
   logic [DELAY_W-1:0] delay_ff, delay_in;

   // The result register lets the sequencer finish while the consumer stalls.
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   kind_type   rsp_type_ff, rsp_type_in;
   logic       rsp_slot_ff, rsp_slot_in;

   start_type     start;
   ctrl_stat_type stat;
   ram_req_type   ram_req;
   entry_type     rd_data;
   logic          done_take;

   // A new word is taken only while the sequencer is idle.
   assign req_stall = !stat.idle;

   assign start.valid     = req_valid && !req_stall;
   assign start.command   = req_command;
   assign start.frame_tag = req_frame_tag;

   // The finished result moves out when the result register is free or draining.
   assign done_take = stat.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      delay_in      = csr_wr_en ? csr_wr_data : delay_ff;
      rsp_valid_in  = done_take ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in = done_take ? stat.status : rsp_status_ff;
      rsp_type_in   = done_take ? stat.coding_kind : rsp_type_ff;
      rsp_slot_in   = done_take ? stat.slot : rsp_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= RETRY_DELAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_coding_kind    = rsp_type_ff;
   assign rsp_long_term_slot = rsp_slot_ff;

   // The sequencer walks the table through the memory's write port and read port.
   ltrfp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .retry_delay (delay_ff),
      .start       (start),
      .done_take   (done_take),
      .rd_data     (rd_data),
      .ram_req     (ram_req),
      .stat        (stat)
   );

   // In-flight frames, oldest first, compacted after every removal.
   ltrfp_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// ===== sv/ltrfp_ram.sv =====
// ----------------------------------------------------------------------------
// Frame table memory
// One write port and one registered read port over the in-flight table.
// ----------------------------------------------------------------------------
module ltrfp_ram (
   input  logic                   clock,
   input  ltrfp_pkg::ram_req_type ram_req,
   output ltrfp_pkg::entry_type   rd_data
);
   import ltrfp_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ltrfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Policy sequencer
// Walks the frame table one entry per step and holds the recovery state.
// ----------------------------------------------------------------------------
`include "long_term_reference_frame_policy_defines.svh"

module ltrfp_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ltrfp_pkg::DELAY_W-1:0]    retry_delay,
   input  ltrfp_pkg::start_type             start,
   input  logic                             done_take,
   input  ltrfp_pkg::entry_type             rd_data,
   output ltrfp_pkg::ram_req_type           ram_req,
   output ltrfp_pkg::ctrl_stat_type         stat
);
   import ltrfp_pkg::*;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [IDX_W-1:0] n_ff, n_in, r_ff, r_in, w_ff, w_in, i_ff, i_in;
   logic [IDX_W-1:0] k_ff, k_in, j_ff, j_in, jp_ff, jp_in;
   logic [TABLE_DEPTH-1:0] mark_ff, mark_in;
   entry_type kent_ff, kent_in;
   logic [COUNT_W-1:0] curref_ff, curref_in;
   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic [COUNT_W-1:0] last_intra_ff, last_intra_in;
   logic [COUNT_W-1:0] refer_count_ff, refer_count_in;
   logic [COUNT_W-1:0] create_count_ff, create_count_in;
   logic [COUNT_W-1:0] good_count_ff, good_count_in;
   logic intra_needed_ff, intra_needed_in, last_bad_ff, last_bad_in;
   logic refer_pend_ff, refer_pend_in, create_pend_ff, create_pend_in;
   logic have_good_ff, have_good_in, good_slot_ff, good_slot_in;
   status_type status_ff, status_in;
   kind_type ftype_ff, ftype_in;
   logic slot_ff, slot_in;

   logic ack_apply, nack_apply;
   entry_type eff_e;
   logic [COUNT_W-1:0] since_intra;
   logic delay_ok, tag_hit;
   cmd_type start_cmd;

   assign start_cmd   = cmd_type'(start.command);
   assign tag_hit     = (rd_data.tag == tag_ff);
   assign since_intra = frame_count_ff + COUNT_W'(1) - last_intra_ff;
   assign delay_ok    = (since_intra >= {{(COUNT_W-DELAY_W){1'b0}}, retry_delay});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start.valid) begin
               case (start_cmd)
                  CMD_NEXT:   state_in = (n_ff > IDX_W'(MAX_INFLIGHT)) ? S_CMP_RD : S_APPEND;
                  CMD_ACK:    state_in = S_FIND_RD;
                  CMD_NACK:   state_in = S_FIND_RD;
                  CMD_BROKEN: state_in = (n_ff == '0) ? S_DONE : S_BRK_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_CMP_RD: begin
            if (r_ff == n_ff) begin
               state_in = (cmd_ff == CMD_NEXT) ? S_APPEND : S_DONE;
            end else if (!mark_ff[r_ff]) begin
               state_in = S_CMP_WR;
            end
         end
         S_CMP_WR:    state_in = S_CMP_RD;
         S_APPEND:    state_in = S_DONE;
         S_FIND_RD:   state_in = (i_ff == n_ff) ? S_DONE : S_FIND_CHK;
         S_FIND_CHK: begin
            if (tag_hit) begin
               state_in = (cmd_ff == CMD_ACK) ? S_ACK_FIRST : S_NK_FIRST;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_ACK_FIRST: state_in = S_ACK_RD;
         S_ACK_RD:    state_in = (jp_ff == '0) ? S_CMP_RD : S_ACK_CHK;
         S_ACK_CHK:   state_in = S_ACK_RD;
         S_BRK_RD:    state_in = S_NK_FIRST;
         S_NK_FIRST:  state_in = S_NK_RDK;
         S_NK_RDK:    state_in = (k_ff == n_ff) ? S_CMP_RD : S_NK_GOTK;
         S_NK_GOTK:   state_in = S_NK_RDJ;
         S_NK_RDJ: begin
            if (j_ff == k_ff) begin
               state_in = S_NK_RDK;
            end else if (mark_ff[j_ff]) begin
               state_in = S_NK_CHKJ;
            end
         end
         S_NK_CHKJ: begin
            state_in = (rd_data.count == kent_ff.ref_count) ? S_NK_RDK : S_NK_RDJ;
         end
         S_DONE:      state_in = done_take ? S_IDLE : S_DONE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cmd_in          = cmd_ff;
      tag_in          = tag_ff;
      n_in            = n_ff;
      r_in            = r_ff;
      w_in            = w_ff;
      i_in            = i_ff;
      k_in            = k_ff;
      j_in            = j_ff;
      jp_in           = jp_ff;
      mark_in         = mark_ff;
      kent_in         = kent_ff;
      curref_in       = curref_ff;
      frame_count_in  = frame_count_ff;
      last_intra_in   = last_intra_ff;
      refer_count_in  = refer_count_ff;
      create_count_in = create_count_ff;
      good_count_in   = good_count_ff;
      intra_needed_in = intra_needed_ff;
      last_bad_in     = last_bad_ff;
      refer_pend_in   = refer_pend_ff;
      create_pend_in  = create_pend_ff;
      have_good_in    = have_good_ff;
      good_slot_in    = good_slot_ff;
      status_in       = status_ff;
      ftype_in        = ftype_ff;
      slot_in         = slot_ff;
      ram_req         = '0;
      ack_apply       = 1'b0;
      nack_apply      = 1'b0;
      eff_e           = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start.valid) begin
               cmd_in    = start_cmd;
               tag_in    = start.frame_tag;
               mark_in   = '0;
               status_in = STATUS_OK;
               ftype_in  = KIND_NORMAL;
               slot_in   = 1'b0;
               i_in      = '0;
               r_in      = '0;
               w_in      = '0;
               case (start_cmd)
                  CMD_NEXT: begin
                     // A full table drops its oldest frame first.
                     if (n_ff > IDX_W'(MAX_INFLIGHT)) begin
                        mark_in[0] = 1'b1;
                     end
                  end
                  CMD_BROKEN: begin
                     if (n_ff == '0) begin
                        intra_needed_in = 1'b1;
                     end else begin
                        i_in = n_ff - IDX_W'(1);
                     end
                  end
                  CMD_FORCE_INTRA: intra_needed_in = 1'b1;
                  default: ;
               endcase
            end
         end
         S_CMP_RD: begin
            if (r_ff == n_ff) begin
               n_in = w_ff;
            end else if (mark_ff[r_ff]) begin
               r_in = r_ff + IDX_W'(1);
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = r_ff;
            end
         end
         S_CMP_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = w_ff;
            ram_req.wr_data = rd_data;
            w_in = w_ff + IDX_W'(1);
            r_in = r_ff + IDX_W'(1);
         end
         S_APPEND: begin
            if (frame_count_ff == '0 || intra_needed_ff || (!have_good_ff && delay_ok) ||
                (last_bad_ff && !have_good_ff)) begin
               ftype_in = KIND_INTRA;
               slot_in  = 1'b0;
               ram_req.wr_data.ref_count = '0;
               intra_needed_in = 1'b0;
               last_bad_in     = 1'b0;
               last_intra_in   = frame_count_ff + COUNT_W'(1);
               refer_pend_in   = 1'b0;
               create_pend_in  = 1'b0;
               have_good_in    = 1'b0;
            end else if (last_bad_ff) begin
               ftype_in = KIND_REFER;
               slot_in  = good_slot_ff;
               ram_req.wr_data.ref_count = good_count_ff;
               last_bad_in    = 1'b0;
               refer_count_in = frame_count_ff + COUNT_W'(1);
               refer_pend_in  = 1'b1;
               create_pend_in = 1'b0;
            end else if (have_good_ff && !refer_pend_ff && !create_pend_ff) begin
               ftype_in = KIND_CREATE;
               slot_in  = ~good_slot_ff;
               ram_req.wr_data.ref_count = frame_count_ff;
               create_count_in = frame_count_ff + COUNT_W'(1);
               create_pend_in  = 1'b1;
            end else begin
               ftype_in = KIND_NORMAL;
               slot_in  = 1'b0;
               ram_req.wr_data.ref_count = frame_count_ff;
            end
            frame_count_in        = frame_count_ff + COUNT_W'(1);
            ram_req.wr_en         = 1'b1;
            ram_req.wr_addr       = n_ff;
            ram_req.wr_data.count = frame_count_ff + COUNT_W'(1);
            ram_req.wr_data.tag   = tag_ff;
            ram_req.wr_data.kind  = ftype_in;
            ram_req.wr_data.slot  = slot_in;
            n_in = n_ff + IDX_W'(1);
         end
         S_FIND_RD: begin
            if (i_ff == n_ff) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = i_ff;
            end
         end
         S_FIND_CHK: begin
            if (!tag_hit) begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         S_ACK_FIRST: begin
            ack_apply     = 1'b1;
            mark_in[i_ff] = 1'b1;
            curref_in     = rd_data.ref_count;
            jp_in         = i_ff;
         end
         S_ACK_RD: begin
            if (jp_ff == '0) begin
               r_in = '0;
               w_in = '0;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = jp_ff - IDX_W'(1);
            end
         end
         S_ACK_CHK: begin
            // The walk steps back one entry; a frame that the chain refers to is marked.
            jp_in = jp_ff - IDX_W'(1);
            if (rd_data.count == curref_ff) begin
               ack_apply = 1'b1;
               mark_in[jp_ff - IDX_W'(1)] = 1'b1;
               curref_in = rd_data.ref_count;
            end
         end
         S_BRK_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = i_ff;
         end
         S_NK_FIRST: begin
            nack_apply    = 1'b1;
            mark_in[i_ff] = 1'b1;
            k_in          = i_ff + IDX_W'(1);
         end
         S_NK_RDK: begin
            if (k_ff == n_ff) begin
               r_in = '0;
               w_in = '0;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = k_ff;
            end
         end
         S_NK_GOTK: begin
            kent_in = rd_data;
            j_in    = i_ff;
         end
         S_NK_RDJ: begin
            if (j_ff != k_ff) begin
               if (mark_ff[j_ff]) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = j_ff;
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end else begin
               // No taken frame feeds this one, so it stays.
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_NK_CHKJ: begin
            if (rd_data.count == kent_ff.ref_count) begin
               nack_apply    = 1'b1;
               eff_e         = kent_ff;
               mark_in[k_ff] = 1'b1;
               k_in          = k_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase

      // An acked frame may confirm a long-term frame or clear a pending refer.
      if (ack_apply && eff_e.count >= last_intra_ff) begin
         if (eff_e.kind == KIND_REFER && eff_e.count == refer_count_ff) begin
            refer_pend_in = 1'b0;
         end
         if (eff_e.kind == KIND_INTRA ||
             (eff_e.kind == KIND_CREATE && eff_e.count == create_count_ff)) begin
            have_good_in  = 1'b1;
            good_slot_in  = eff_e.slot;
            good_count_in = eff_e.count;
            if (eff_e.kind == KIND_CREATE) begin
               create_pend_in = 1'b0;
            end
         end
      end

      // A lost frame cancels any pending long-term action it carried and flags a lost newest frame.
      if (nack_apply) begin
         if (eff_e.count == frame_count_ff) begin
            last_bad_in = 1'b1;
         end
         if (eff_e.count >= last_intra_ff) begin
            if (eff_e.kind == KIND_REFER) begin
               refer_pend_in = 1'b0;
            end
            if (eff_e.kind == KIND_CREATE) begin
               create_pend_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         n_ff            <= '0;
         frame_count_ff  <= '0;
         last_intra_ff   <= '0;
         refer_count_ff  <= '0;
         create_count_ff <= '0;
         good_count_ff   <= '0;
         intra_needed_ff <= 1'b0;
         last_bad_ff     <= 1'b0;
         refer_pend_ff   <= 1'b0;
         create_pend_ff  <= 1'b0;
         have_good_ff    <= 1'b0;
         good_slot_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         n_ff            <= n_in;
         frame_count_ff  <= frame_count_in;
         last_intra_ff   <= last_intra_in;
         refer_count_ff  <= refer_count_in;
         create_count_ff <= create_count_in;
         good_count_ff   <= good_count_in;
         intra_needed_ff <= intra_needed_in;
         last_bad_ff     <= last_bad_in;
         refer_pend_ff   <= refer_pend_in;
         create_pend_ff  <= create_pend_in;
         have_good_ff    <= have_good_in;
         good_slot_ff    <= good_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      tag_ff    <= tag_in;
      r_ff      <= r_in;
      w_ff      <= w_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      jp_ff     <= jp_in;
      mark_ff   <= mark_in;
      kent_ff   <= kent_in;
      curref_ff <= curref_in;
      status_ff <= status_in;
      ftype_ff  <= ftype_in;
      slot_ff   <= slot_in;
   end

   // Outputs.
   always_comb begin
      stat.idle        = (state_ff == S_IDLE);
      stat.done        = (state_ff == S_DONE);
      stat.status      = status_ff;
      stat.coding_kind = ftype_ff;
      stat.slot        = slot_ff;
   end

   `LTRFP_ASSERT_ALWAYS(a_table_bound, clock, reset, n_ff <= IDX_W'(TABLE_DEPTH))
   `LTRFP_ASSERT_IMPL(a_no_write_idle, clock, reset, state_ff == S_IDLE, !ram_req.wr_en)
   `LTRFP_ASSERT_IMPL(a_type_only_next, clock, reset, stat.done && cmd_ff != CMD_NEXT, ftype_ff == KIND_NORMAL && !slot_ff)
   `LTRFP_ASSERT_IMPL(a_status_lookup, clock, reset, stat.done && status_ff == STATUS_NOT_FOUND, cmd_ff == CMD_ACK || cmd_ff == CMD_NACK)
   `LTRFP_ASSERT_NEXT(a_append_grows, clock, reset, state_ff == S_APPEND, n_ff == $past(n_ff) + IDX_W'(1))

endmodule

// ===== tb/long_term_reference_frame_policy_tb.sv =====
// ----------------------------------------------------------------------------
// Long-term reference frame policy testbench
// Drives frame commands, acks, nacks and recovery requests into the policy
// block under random idling and a long receiver hold-off, predicts every
// result word with a behavioral model of the frame table, and compares the
// words field by field in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module long_term_reference_frame_policy_tb;
   import ltrfp_pkg::*;

   typedef struct packed {
      logic       status;
      logic [1:0] coding_kind;
      logic       slot;
   } policy_word_type;

   typedef struct {
      logic [63:0] count;
      logic [63:0] ref_count;
      logic [31:0] tag;
      kind_type    kind;
      logic        slot;
   } frame_rec_type;

   // Scoreboard: holds the predicted words in order and checks each arrival.
   class policy_scoreboard;
      policy_word_type pending_words[$];
      int              fail_count;

      function void note_input(policy_word_type w);
         pending_words.push_back(w);
      endfunction

      task report_mismatch(string msg);
         fail_count++;
         $display("mismatch: %s", msg);
      endtask

      task check_word(policy_word_type got);
         policy_word_type exp_w;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %b", got));
            return;
         end
         exp_w = pending_words.pop_front();
         if (got.status !== exp_w.status) begin
            report_mismatch($sformatf("status got %b want %b", got.status, exp_w.status));
         end
         if (got.coding_kind !== exp_w.coding_kind) begin
            report_mismatch($sformatf("coding kind got %0d want %0d",
                                      got.coding_kind, exp_w.coding_kind));
         end
         if (got.slot !== exp_w.slot) begin
            report_mismatch($sformatf("slot got %b want %b", got.slot, exp_w.slot));
         end
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   logic [2:0]      req_command;
   logic [31:0]     req_frame_tag;
   logic            rsp_valid;
   logic            rsp_stall;
   logic            rsp_status;
   logic [1:0]      rsp_coding_kind;
   logic            rsp_long_term_slot;
   logic            csr_wr_en;
   logic [15:0]     csr_wr_data;

   policy_scoreboard sb;
   int unsigned     cycle_count;
   int              hold_off_cycles;

   // Model state of the policy: counters, recovery flags and the frame table.
   logic [15:0]     m_delay;
   logic [63:0]     m_frame_count, m_last_intra, m_refer_count, m_create_count;
   logic [63:0]     m_good_count;
   bit              m_intra_needed, m_last_bad, m_refer_pend, m_create_pend;
   bit              m_have_good;
   logic            m_good_slot;
   frame_rec_type   frames[$];
   logic [31:0]     recent_tags[$];

   long_term_reference_frame_policy DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_frame_tag(req_frame_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_coding_kind(rsp_coding_kind),
      .rsp_long_term_slot(rsp_long_term_slot),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Removes the marked frames and keeps the others in age order.
   function automatic void drop_marked(bit mark[$]);
      frame_rec_type kept[$];
      for (int r = 0; r < frames.size(); r++) begin
         if (!mark[r]) kept.push_back(frames[r]);
      end
      frames = kept;
   endfunction

   function automatic void apply_ack(int idx);
      bit mark[$];
      int cur, j;
      frame_rec_type f;
      for (int r = 0; r < frames.size(); r++) mark.push_back(1'b0);
      cur = idx;
      forever begin
         f = frames[cur];
         // Acks of frames older than the last intra frame carry no news.
         if (f.count >= m_last_intra) begin
            if (f.kind == KIND_REFER && f.count == m_refer_count) m_refer_pend = 0;
            if (f.kind == KIND_INTRA ||
                (f.kind == KIND_CREATE && f.count == m_create_count)) begin
               m_have_good = 1;
               m_good_slot = f.slot;
               m_good_count = f.count;
               if (f.kind == KIND_CREATE) m_create_pend = 0;
            end
         end
         mark[cur] = 1'b1;
         j = cur - 1;
         while (j >= 0 && frames[j].count != f.ref_count) j--;
         if (j < 0) break;
         cur = j;
      end
      drop_marked(mark);
   endfunction

   // A nack also takes out every later frame that references a taken one.
   function automatic void apply_nack(int idx);
      bit mark[$];
      for (int r = 0; r < frames.size(); r++) mark.push_back(r == idx);
      for (int k = idx + 1; k < frames.size(); k++) begin
         for (int j = idx; j < k; j++) begin
            if (mark[j] && frames[k].ref_count == frames[j].count) begin
               mark[k] = 1'b1;
               break;
            end
         end
      end
      for (int k = idx; k < frames.size(); k++) begin
         if (mark[k]) begin
            if (frames[k].count == m_frame_count) m_last_bad = 1;
            if (frames[k].count >= m_last_intra) begin
               if (frames[k].kind == KIND_REFER) m_refer_pend = 0;
               if (frames[k].kind == KIND_CREATE) m_create_pend = 0;
            end
         end
      end
      drop_marked(mark);
   endfunction

   function automatic policy_word_type predict_policy(logic [2:0] cmd, logic [31:0] tag);
      policy_word_type w;
      frame_rec_type   f;
      int              idx;
      w = '0;
      case (cmd)
         CMD_NEXT: begin
            while (frames.size() > MAX_INFLIGHT) void'(frames.pop_front());
            f.slot = 1'b0;
            if (m_frame_count == 0 || m_intra_needed ||
                (!m_have_good && (m_frame_count + 64'd1 - m_last_intra) >= {48'd0, m_delay}) ||
                (m_last_bad && !m_have_good)) begin
               f.kind = KIND_INTRA; f.ref_count = '0;
               m_intra_needed = 0; m_last_bad = 0;
            end else if (m_last_bad) begin
               f.kind = KIND_REFER; f.slot = m_good_slot; f.ref_count = m_good_count;
               m_last_bad = 0;
            end else if (m_have_good && !m_refer_pend && !m_create_pend) begin
               f.kind = KIND_CREATE; f.slot = ~m_good_slot; f.ref_count = m_frame_count;
            end else begin
               f.kind = KIND_NORMAL; f.ref_count = m_frame_count;
            end
            m_frame_count++;
            f.count = m_frame_count;
            f.tag = tag;
            frames.push_back(f);
            case (f.kind)
               KIND_INTRA: begin
                  m_last_intra = m_frame_count;
                  m_refer_pend = 0; m_create_pend = 0; m_have_good = 0;
               end
               KIND_REFER: begin
                  m_refer_count = m_frame_count; m_refer_pend = 1; m_create_pend = 0;
               end
               KIND_CREATE: begin
                  m_create_count = m_frame_count; m_create_pend = 1;
               end
               default: ;
            endcase
            w.coding_kind = f.kind;
            w.slot = f.slot;
         end
         CMD_ACK, CMD_NACK: begin
            idx = -1;
            for (int i = 0; i < frames.size(); i++) begin
               if (frames[i].tag == tag) begin
                  idx = i;
                  break;
               end
            end
            if (idx < 0) w.status = STATUS_NOT_FOUND;
            else if (cmd == CMD_ACK) apply_ack(idx);
            else apply_nack(idx);
         end
         CMD_BROKEN: begin
            if (frames.size() == 0) m_intra_needed = 1;
            else apply_nack(frames.size() - 1);
         end
         CMD_FORCE_INTRA: m_intra_needed = 1;
         default: ;
      endcase
      return w;
   endfunction

   // Offers one word after a random gap and waits until it is taken. The valid
   // stays high after the handshake and drops only when a gap follows.
   task automatic send_word(logic [2:0] cmd, logic [31:0] tag);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_frame_tag <= tag;
      do @(posedge clock); while (req_stall);
      sb.note_input(predict_policy(cmd, tag));
      if (cmd == CMD_NEXT) begin
         recent_tags.push_back(tag);
         if (recent_tags.size() > 80) void'(recent_tags.pop_front());
      end
   endtask

   // Writes the retry delay once the block has drained.
   task automatic write_delay(logic [15:0] value);
      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      m_delay = value;
   endtask

   // Tags of recently sent frames are looked up most of the time.
   function automatic logic [31:0] pick_tag();
      if (recent_tags.size() != 0 && $urandom_range(0, 9) < 8)
         return recent_tags[$urandom_range(0, recent_tags.size() - 1)];
      return $urandom();
   endfunction

   task automatic random_phase(int count);
      int roll;
      logic [2:0] cmd;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) cmd = CMD_NEXT;
         else if (roll < 70) cmd = CMD_ACK;
         else if (roll < 88) cmd = CMD_NACK;
         else if (roll < 94) cmd = CMD_BROKEN;
         else if (roll < 98) cmd = CMD_FORCE_INTRA;
         else cmd = 3'($urandom_range(5, 7));
         send_word(cmd, cmd == CMD_NEXT ? logic'($urandom_range(0, 3) == 0) ?
                   32'($urandom()) : 32'(m_frame_count + 100) : pick_tag());
      end
   endtask

   // The receiver stalls for a random gap before each word, except for
   // one long hold-off while the sender keeps offering words so the block
   // backs up into its input.
   initial begin
      int rgap;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
            hold_off_cycles--;
         end else begin
            rgap = $urandom_range(0, 3);
            if (rgap != 0) begin
               rsp_stall <= 1'b1;
               repeat (rgap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   // Every accepted result word goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word({rsp_status, rsp_coding_kind, rsp_long_term_slot});
   end

   // Run limit, far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 40000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      sb = new();
      cycle_count = 0;
      hold_off_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_NEXT;
      req_frame_tag = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      m_delay = RETRY_DELAY_RESET;
      m_frame_count = 0; m_last_intra = 0; m_refer_count = 0;
      m_create_count = 0; m_good_count = 0;
      m_intra_needed = 0; m_last_bad = 0; m_refer_pend = 0;
      m_create_pend = 0; m_have_good = 0; m_good_slot = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: unknown tags on an empty table, broken stream with no
      // frames, an ack that establishes a good frame, creation and referral of
      // long-term frames, a nack closing over dependents, force intra, the
      // unused commands, and the extreme tag values.
      send_word(CMD_ACK, 32'hFFFF_FFFF);
      send_word(CMD_NACK, 32'h0);
      send_word(CMD_BROKEN, 32'h0);
      send_word(CMD_NEXT, 32'h0);
      send_word(CMD_NEXT, 32'hFFFF_FFFF);
      send_word(CMD_ACK, 32'h0);
      send_word(CMD_NEXT, 32'h5555_5555);
      send_word(CMD_NEXT, 32'hAAAA_AAAA);
      send_word(CMD_ACK, 32'h5555_5555);
      send_word(CMD_NEXT, 32'h10);
      send_word(CMD_NEXT, 32'h11);
      send_word(CMD_NACK, 32'h10);
      send_word(CMD_NEXT, 32'h12);
      send_word(CMD_NEXT, 32'h13);
      send_word(CMD_BROKEN, 32'h0);
      send_word(CMD_FORCE_INTRA, 32'h0);
      send_word(CMD_NEXT, 32'h14);
      send_word(3'd5, 32'hFFFF_FFFF);
      send_word(3'd6, 32'h1);
      send_word(3'd7, 32'h2);

      // Overfill the table so the oldest frames are trimmed.
      write_delay(16'hFFFF);
      for (int i = 0; i < 70; i++) send_word(CMD_NEXT, 32'(1000 + i));
      send_word(CMD_ACK, 32'd1000);
      send_word(CMD_ACK, 32'd1069);

      // Retry delay near its low extreme, then random traffic with a long
      // receiver hold-off while the sender keeps going.
      write_delay(16'd1);
      hold_off_cycles = 400;
      random_phase(400);
      write_delay(16'd0);
      random_phase(200);
      write_delay(16'd5);
      random_phase(500);
      write_delay(16'hFFFF);
      random_phase(300);
      write_delay(RETRY_DELAY_RESET);
      random_phase(400);

      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ltrfp_pkg.sv
sv/ltrfp_ram.sv
sv/ltrfp_ctrl.sv
sv/long_term_reference_frame_policy.sv
tb/long_term_reference_frame_policy_tb.sv
